/* rtl/jhds_pkg.sv */
// ----------------------------------------------------------------------------
// jhds_pkg
// Types and constants for the JPEG header dimension scanner.
// ----------------------------------------------------------------------------
package jhds_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned DIM_W    = 16;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned COMP_W   = 8;
    localparam int unsigned SKIP_W   = 16;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [STATUS_W-1:0] ST_SCAN     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_JPEG = 4'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PFX  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_PROG     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SOS      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EOI      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BAD_COMP = 4'd8;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 4'd10;

    localparam logic [DATA_W-1:0] MK_PREFIX = 8'hff;
    localparam logic [DATA_W-1:0] MK_SOI    = 8'hd8;
    localparam logic [DATA_W-1:0] MK_APP_LO = 8'he0;
    localparam logic [DATA_W-1:0] MK_APP_HI = 8'hef;
    localparam logic [DATA_W-1:0] MK_COM    = 8'hfe;
    localparam logic [DATA_W-1:0] MK_DQT    = 8'hdb;
    localparam logic [DATA_W-1:0] MK_DHT    = 8'hc4;
    localparam logic [DATA_W-1:0] MK_SOF0   = 8'hc0;
    localparam logic [DATA_W-1:0] MK_SOF2   = 8'hc2;
    localparam logic [DATA_W-1:0] MK_SOS    = 8'hda;
    localparam logic [DATA_W-1:0] MK_EOI    = 8'hd9;

    localparam logic [SKIP_W-1:0] SOF_PAD_LEN = 16'd3;
    localparam logic [SKIP_W-1:0] LEN_MIN     = 16'd2;
    localparam logic [COMP_W-1:0] COMP_GREY   = 8'd1;
    localparam logic [COMP_W-1:0] COMP_COLOUR = 8'd3;

    typedef enum logic [12:0] {
        PH_MAGIC0  = 13'b0_0000_0000_0001,
        PH_MAGIC1  = 13'b0_0000_0000_0010,
        PH_MARK0   = 13'b0_0000_0000_0100,
        PH_MARK1   = 13'b0_0000_0000_1000,
        PH_LEN_HI  = 13'b0_0000_0001_0000,
        PH_LEN_LO  = 13'b0_0000_0010_0000,
        PH_SKIP    = 13'b0_0000_0100_0000,
        PH_SOF_PAD = 13'b0_0000_1000_0000,
        PH_H_HI    = 13'b0_0001_0000_0000,
        PH_H_LO    = 13'b0_0010_0000_0000,
        PH_W_HI    = 13'b0_0100_0000_0000,
        PH_W_LO    = 13'b0_1000_0000_0000,
        PH_COMP    = 13'b1_0000_0000_0000
    } phase_t;

endpackage

/* rtl/jpeg_header_dimension_scanner.sv */
// ----------------------------------------------------------------------------
// jpeg_header_dimension_scanner
// Walks JPEG marker segments a byte at a time and captures the SOF0 size.
//
//   channel  dir  beats       contents
//   s_       in   one byte    tdata: data_byte; tuser: restart; tlast: last
//   m_       out  one result  tdata: status, height, width, component count
//
// A new byte is taken every cycle while m_tready is high.
// The parse state and the result register update together on acceptance.
// A single output register holds the result; s_tready drops only while it
// is full and m_tready is low. Reset clears the parse state to expect the
// start-of-image marker with status scanning.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_scanner (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jhds_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] data_byte
    input  logic                               s_tuser,  // [0] restart
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] status, [19:4] image_height, [35:20] image_width,
    // [43:36] component_count, [47:44] zero
    output logic [jhds_pkg::M_TDATA_W-1:0]     m_tdata
);
    import jhds_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [SKIP_W-1:0]     skip_reg, skip_next;
    logic [DATA_W-1:0]     len_hi_reg, len_hi_next;
    logic [DIM_W-1:0]      height_reg, height_next;
    logic [DIM_W-1:0]      width_reg, width_next;
    logic [COMP_W-1:0]     comp_reg, comp_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  accept;
    logic [DATA_W-1:0]     b;
    logic [SKIP_W-1:0]     seg_len;
    logic [SKIP_W-1:0]     skip_dec;

    assign b        = s_tdata[DATA_W-1:0];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign seg_len  = {len_hi_reg, b};
    assign skip_dec = skip_reg - 16'd1;

    always_comb begin
        if (s_tuser) begin
            phase_next  = PH_MAGIC0;
            skip_next   = '0;
            len_hi_next = '0;
            height_next = '0;
            width_next  = '0;
            comp_next   = '0;
            status_next = ST_SCAN;
        end else begin
            phase_next  = phase_reg;
            skip_next   = skip_reg;
            len_hi_next = len_hi_reg;
            height_next = height_reg;
            width_next  = width_reg;
            comp_next   = comp_reg;
            status_next = status_reg;
        end

        if (status_next == ST_SCAN) begin
            case (phase_next)
                PH_MAGIC0: begin
                    if (b == MK_PREFIX) phase_next = PH_MAGIC1;
                    else status_next = ST_NOT_JPEG;
                end
                PH_MAGIC1: begin
                    if (b == MK_SOI) phase_next = PH_MARK0;
                    else status_next = ST_NOT_JPEG;
                end
                PH_MARK1: begin
                    if ((b >= MK_APP_LO && b <= MK_APP_HI) || b == MK_COM ||
                        b == MK_DQT || b == MK_DHT) begin
                        phase_next = PH_LEN_HI;
                    end else if (b == MK_SOF0) begin
                        skip_next  = SOF_PAD_LEN;
                        phase_next = PH_SOF_PAD;
                    end else if (b == MK_SOF2) begin
                        status_next = ST_PROG;
                    end else if (b == MK_SOS) begin
                        status_next = ST_SOS;
                    end else if (b == MK_EOI) begin
                        status_next = ST_EOI;
                    end else begin
                        status_next = ST_UNKNOWN;
                    end
                end
                PH_LEN_HI: begin
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (seg_len < LEN_MIN) begin
                        status_next = ST_BAD_LEN;
                    end else begin
                        skip_next  = seg_len - LEN_MIN;
                        phase_next = (seg_len == LEN_MIN) ? PH_MARK0 : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = PH_MARK0;
                end
                PH_SOF_PAD: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = PH_H_HI;
                end
                PH_H_HI: begin
                    height_next = {b, 8'h00};
                    phase_next  = PH_H_LO;
                end
                PH_H_LO: begin
                    height_next = {height_next[DIM_W-1:DATA_W], b};
                    phase_next  = PH_W_HI;
                end
                PH_W_HI: begin
                    width_next = {b, 8'h00};
                    phase_next = PH_W_LO;
                end
                PH_W_LO: begin
                    width_next = {width_next[DIM_W-1:DATA_W], b};
                    phase_next = PH_COMP;
                end
                PH_COMP: begin
                    comp_next   = b;
                    status_next = (b == COMP_GREY || b == COMP_COLOUR) ? ST_FOUND
                                                                       : ST_BAD_COMP;
                end
                default: begin
                    if (b == MK_PREFIX) phase_next = PH_MARK1;
                    else status_next = ST_BAD_PFX;
                end
            endcase
            if (s_tlast && status_next == ST_SCAN) status_next = ST_TRUNC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC0;
            skip_reg    <= '0;
            len_hi_reg  <= '0;
            height_reg  <= '0;
            width_reg   <= '0;
            comp_reg    <= '0;
            status_reg  <= ST_SCAN;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                len_hi_reg  <= len_hi_next;
                height_reg  <= height_next;
                width_reg   <= width_next;
                comp_reg    <= comp_next;
                status_reg  <= status_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {4'h0, comp_next, width_next, height_next, status_next};
        end
    end

endmodule

/* tb/tb_jpeg_header_dimension_scanner.sv */
// ----------------------------------------------------------------------------
// tb_jpeg_header_dimension_scanner
// Self-checking bench for the JPEG header dimension scanner. Feeds JPEG-like
// byte files (marker segments, SOF0 frames, corrupted and cut-short files,
// random noise) under varying source gaps and sink back-pressure, and checks
// every result item against a scan model in the bench or a row's own result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jpeg_header_dimension_scanner;

    import jhds_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [COMP_W-1:0]   comps;
    } scan_result_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              restart;
        logic              last;
        logic              typed;
        scan_result_t      want;
    } byte_row_t;

    localparam int unsigned HEADER_ROWS = 35;
    localparam int unsigned ITEMS_PER_PHASE = 425;

    localparam byte_row_t header_rows [HEADER_ROWS] = '{
        '{MK_PREFIX,   1'b1, 1'b0, 1'b1, '{ST_SCAN, 16'd0, 16'd0, 8'd0}},
        '{MK_SOI,      1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b0, '0},
        '{MK_APP_HI,   1'b0, 1'b0, 1'b0, '0},
        '{8'h00,       1'b0, 1'b0, 1'b0, '0},
        '{8'h02,       1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b0, '0},
        '{MK_SOF0,     1'b0, 1'b0, 1'b0, '0},
        '{8'h00,       1'b0, 1'b0, 1'b0, '0},
        '{8'h11,       1'b0, 1'b0, 1'b0, '0},
        '{8'h08,       1'b0, 1'b0, 1'b0, '0},
        '{8'hff,       1'b0, 1'b0, 1'b0, '0},
        '{8'hff,       1'b0, 1'b0, 1'b0, '0},
        '{8'hff,       1'b0, 1'b0, 1'b0, '0},
        '{8'hff,       1'b0, 1'b0, 1'b0, '0},
        '{COMP_COLOUR, 1'b0, 1'b1, 1'b1, '{ST_FOUND, 16'hffff, 16'hffff, COMP_COLOUR}},
        '{8'h00,       1'b0, 1'b0, 1'b1, '{ST_FOUND, 16'hffff, 16'hffff, COMP_COLOUR}},
        '{8'h00,       1'b1, 1'b0, 1'b1, '{ST_NOT_JPEG, 16'd0, 16'd0, 8'd0}},
        '{MK_PREFIX,   1'b1, 1'b0, 1'b0, '0},
        '{8'h00,       1'b0, 1'b0, 1'b1, '{ST_NOT_JPEG, 16'd0, 16'd0, 8'd0}},
        '{MK_PREFIX,   1'b1, 1'b0, 1'b0, '0},
        '{MK_SOI,      1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b0, '0},
        '{MK_SOF2,     1'b0, 1'b0, 1'b1, '{ST_PROG, 16'd0, 16'd0, 8'd0}},
        '{MK_PREFIX,   1'b1, 1'b0, 1'b0, '0},
        '{MK_SOI,      1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b0, '0},
        '{MK_DQT,      1'b0, 1'b0, 1'b0, '0},
        '{8'h00,       1'b0, 1'b0, 1'b0, '0},
        '{8'h01,       1'b0, 1'b0, 1'b1, '{ST_BAD_LEN, 16'd0, 16'd0, 8'd0}},
        '{MK_PREFIX,   1'b1, 1'b1, 1'b1, '{ST_TRUNC, 16'd0, 16'd0, 8'd0}},
        '{MK_PREFIX,   1'b1, 1'b0, 1'b0, '0},
        '{MK_SOI,      1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b0, '0},
        '{MK_PREFIX,   1'b0, 1'b0, 1'b1, '{ST_UNKNOWN, 16'd0, 16'd0, 8'd0}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // [7:0] data_byte
    logic                 s_tuser = 1'b0;  // [0] restart
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    // [3:0] status, [19:4] image_height, [35:20] image_width,
    // [43:36] component_count, [47:44] zero
    logic [M_TDATA_W-1:0] m_tdata;

    byte_row_t    drive_row = '0;
    scan_result_t expected_scans[$];
    int unsigned  idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  faults = 0;
    int unsigned  items_sent = 0;
    int unsigned  bytes_taken = 0;
    int unsigned  files_started = 0;
    int unsigned  results_checked = 0;
    int unsigned  outcome_hits [16];

    phase_t              scan_phase = PH_MAGIC0;
    logic [SKIP_W-1:0]   skip_left = '0;
    logic [DATA_W-1:0]   len_msb = '0;
    logic [DIM_W-1:0]    cap_height = '0;
    logic [DIM_W-1:0]    cap_width = '0;
    logic [COMP_W-1:0]   cap_comps = '0;
    logic [STATUS_W-1:0] scan_status = ST_SCAN;

    jpeg_header_dimension_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_jpeg_header_dimension_scanner: errors");
        $finish;
    end

    function automatic scan_result_t scan_byte(input logic [DATA_W-1:0] b, input logic restart,
                                               input logic last);
        logic [SKIP_W-1:0] seg_len;
        if (restart) begin
            scan_phase  = PH_MAGIC0;
            skip_left   = '0;
            len_msb     = '0;
            cap_height  = '0;
            cap_width   = '0;
            cap_comps   = '0;
            scan_status = ST_SCAN;
        end
        if (scan_status == ST_SCAN) begin
            case (scan_phase)
                PH_MAGIC0: begin
                    if (b == MK_PREFIX) scan_phase = PH_MAGIC1;
                    else scan_status = ST_NOT_JPEG;
                end
                PH_MAGIC1: begin
                    if (b == MK_SOI) scan_phase = PH_MARK0;
                    else scan_status = ST_NOT_JPEG;
                end
                PH_MARK1: begin
                    if ((b >= MK_APP_LO && b <= MK_APP_HI) || b == MK_COM || b == MK_DQT
                        || b == MK_DHT) begin
                        scan_phase = PH_LEN_HI;
                    end else if (b == MK_SOF0) begin
                        skip_left  = SOF_PAD_LEN;
                        scan_phase = PH_SOF_PAD;
                    end else if (b == MK_SOF2) begin
                        scan_status = ST_PROG;
                    end else if (b == MK_SOS) begin
                        scan_status = ST_SOS;
                    end else if (b == MK_EOI) begin
                        scan_status = ST_EOI;
                    end else begin
                        scan_status = ST_UNKNOWN;
                    end
                end
                PH_LEN_HI: begin
                    len_msb    = b;
                    scan_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    seg_len = {len_msb, b};
                    if (seg_len < LEN_MIN) begin
                        scan_status = ST_BAD_LEN;
                    end else begin
                        skip_left  = seg_len - LEN_MIN;
                        scan_phase = (skip_left == 0) ? PH_MARK0 : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0) scan_phase = PH_MARK0;
                end
                PH_SOF_PAD: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0) scan_phase = PH_H_HI;
                end
                PH_H_HI: begin
                    cap_height = {b, 8'h00};
                    scan_phase = PH_H_LO;
                end
                PH_H_LO: begin
                    cap_height[7:0] = b;
                    scan_phase      = PH_W_HI;
                end
                PH_W_HI: begin
                    cap_width  = {b, 8'h00};
                    scan_phase = PH_W_LO;
                end
                PH_W_LO: begin
                    cap_width[7:0] = b;
                    scan_phase     = PH_COMP;
                end
                PH_COMP: begin
                    cap_comps   = b;
                    scan_status = (b == COMP_GREY || b == COMP_COLOUR) ? ST_FOUND : ST_BAD_COMP;
                end
                default: begin
                    if (b == MK_PREFIX) scan_phase = PH_MARK1;
                    else scan_status = ST_BAD_PFX;
                end
            endcase
            if (last && scan_status == ST_SCAN) scan_status = ST_TRUNC;
            if (scan_status != ST_SCAN) outcome_hits[scan_status]++;
        end
        return '{scan_status, cap_height, cap_width, cap_comps};
    endfunction

    function automatic void check_field(input string name, input logic [DIM_W-1:0] want,
                                        input logic [DIM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge aclk) begin : result_monitor
        scan_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = scan_byte(s_tdata, s_tuser, s_tlast);
                if (drive_row.typed) want = drive_row.want;
                expected_scans.push_back(want);
                bytes_taken++;
                if (s_tuser) files_started++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_scans.size() == 0) begin
                    $error("result item with nothing pending: %h", m_tdata);
                    faults++;
                end else begin
                    want = expected_scans.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tdata[3:0]));
                    check_field("image_height", want.height, m_tdata[19:4]);
                    check_field("image_width", want.width, m_tdata[35:20]);
                    check_field("component_count", 16'(want.comps), 16'(m_tdata[43:36]));
                    check_field("pad", '0, 16'(m_tdata[47:44]));
                    results_checked++;
                end
            end
        end
    end

    task automatic send_row(input byte_row_t row);
        s_tvalid  <= 1'b1;
        s_tdata   <= row.data;
        s_tuser   <= row.restart;
        s_tlast   <= row.last;
        drive_row <= row;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic send_file();
        logic [DATA_W-1:0] bytes_q[$];
        logic [DIM_W-1:0]  dim;
        int unsigned       pick;
        int unsigned       seg_len;
        int unsigned       idx;
        int unsigned       n;
        bit                broken;
        bit                noise;
        byte_row_t         row;
        broken = ($urandom_range(0, 99) < 15);
        noise  = ($urandom_range(0, 99) < 6);
        if (noise) begin
            repeat ($urandom_range(1, 5)) bytes_q.push_back(8'($urandom));
        end else begin
            bytes_q.push_back(MK_PREFIX);
            bytes_q.push_back(MK_SOI);
            repeat ($urandom_range(0, 3)) begin
                bytes_q.push_back(MK_PREFIX);
                case ($urandom_range(0, 3))
                    0: bytes_q.push_back(MK_APP_LO | 8'($urandom_range(0, 15)));
                    1: bytes_q.push_back(MK_COM);
                    2: bytes_q.push_back(MK_DQT);
                    default: bytes_q.push_back(MK_DHT);
                endcase
                if (broken && $urandom_range(0, 3) == 0) seg_len = $urandom_range(0, 1);
                else if ($urandom_range(0, 24) == 0) seg_len = $urandom_range(2, 600);
                else seg_len = $urandom_range(2, 9);
                bytes_q.push_back(8'(seg_len >> 8));
                bytes_q.push_back(8'(seg_len));
                for (n = 2; n < seg_len; n++) bytes_q.push_back(8'($urandom));
            end
            bytes_q.push_back(MK_PREFIX);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                bytes_q.push_back(MK_SOF0);
                repeat (3) bytes_q.push_back(8'($urandom));
                repeat (2) begin
                    case ($urandom_range(0, 7))
                        0: dim = '0;
                        1: dim = '1;
                        default: dim = 16'($urandom);
                    endcase
                    bytes_q.push_back(dim[15:8]);
                    bytes_q.push_back(dim[7:0]);
                end
                pick = $urandom_range(0, 9);
                bytes_q.push_back(pick < 4 ? COMP_GREY : pick < 8 ? COMP_COLOUR
                                  : 8'($urandom));
            end else if (pick < 68) begin
                bytes_q.push_back(MK_SOF2);
            end else if (pick < 76) begin
                bytes_q.push_back(MK_SOS);
            end else if (pick < 84) begin
                bytes_q.push_back(MK_EOI);
            end else if (pick < 90) begin
                bytes_q.push_back(MK_PREFIX);
            end else begin
                bytes_q.push_back(8'($urandom));
            end
            repeat ($urandom_range(0, 2)) bytes_q.push_back(8'($urandom));
        end
        if (broken) begin
            idx = $urandom_range(0, bytes_q.size() - 1);
            if ($urandom_range(0, 1)) bytes_q[idx] = 8'($urandom);
            else while (bytes_q.size() > idx + 1) void'(bytes_q.pop_back());
        end
        for (n = 0; n < bytes_q.size(); n++) begin
            row         = '0;
            row.data    = bytes_q[n];
            row.restart = (n == 0) && (!noise || $urandom_range(0, 1));
            row.last    = (n == bytes_q.size() - 1) && ($urandom_range(0, 19) != 0);
            send_row(row);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_no;
        int unsigned i;
        int unsigned outcomes_seen;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  <= 65;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 65;
                end
                default: begin
                    idle_pct  <= 37;
                    stall_pct <= 37;
                end
            endcase
            if (phase_no == 0) begin
                for (i = 0; i < HEADER_ROWS; i++) send_row(header_rows[i]);
            end
            while (items_sent < (phase_no + 1) * ITEMS_PER_PHASE) send_file();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_scans.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        outcomes_seen = 0;
        for (i = 32'(ST_FOUND); i <= 32'(ST_BAD_LEN); i++) begin
            if (outcome_hits[i] != 0) outcomes_seen++;
        end
        $display("%0d bytes taken over %0d restarted files, %0d results checked",
                 bytes_taken, files_started, results_checked);
        $display("%0d of 10 scan outcomes reached, %0d frame sizes captured",
                 outcomes_seen, outcome_hits[ST_FOUND]);
        if (faults == 0) begin
            $display("tb_jpeg_header_dimension_scanner: clean");
        end else begin
            $display("tb_jpeg_header_dimension_scanner: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/jhds_pkg.sv
rtl/jpeg_header_dimension_scanner.sv
tb/tb_jpeg_header_dimension_scanner.sv
